// ===== rtl/nonneg_diophantine_check_defines.svh =====
// Assertion macros for the nonnegative Diophantine check block.
// Included by the top level; no other dependencies.
`ifndef NONNEG_DIOPHANTINE_CHECK_DEFINES_SVH
`define NONNEG_DIOPHANTINE_CHECK_DEFINES_SVH
`ifndef ASSERT_OFF
`define NDC_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define NDC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NDC_ASSERT_IMPL(label, clk, rst_n, cond, msg)
`define NDC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/ndc_pkg.sv =====
// Shared types and constants for the nonnegative Diophantine check.
// No dependencies.
package ndc_pkg;
    localparam int unsigned DefWidth = 16;

    // datapath operations
    typedef enum logic [3:0] {
        t_OP_NONE,
        t_OP_LOAD,
        t_OP_DIV_START,
        t_OP_EUCLID_STEP,
        t_OP_CG_START,
        t_OP_SAVE_CG,
        t_OP_BP_START,
        t_OP_SAVE_BP,
        t_OP_M_START,
        t_OP_SAVE_M,
        t_OP_XM_START,
        t_OP_MUL_START,
        t_OP_XMIN_START,
        t_OP_FINAL_MUL
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic r1_zero;
        logic a_zero;
        logic b_zero;
    } t_status;
endpackage

// ===== rtl/ndc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Uses no package.
module ndc_divider #(
    parameter int unsigned W = 34
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int unsigned CW = $clog2(W + 1);
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W-1:0]  r_q, r_r, r_d;
    logic [W:0]    n_trial;

    assign n_trial = {r_r, r_q[W-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
            r_q    <= i_num;
            r_r    <= '0;
            r_d    <= i_den;
        end else if (r_busy) begin
            if (n_trial[W]) begin
                r_r <= {r_r[W-2:0], r_q[W-1]};
                r_q <= {r_q[W-2:0], 1'b0};
            end else begin
                r_r <= n_trial[W-1:0];
                r_q <= {r_q[W-2:0], 1'b1};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule

// ===== rtl/ndc_datapath.sv =====
// Datapath: Euclid registers, coefficient, scaling and final test.
// Depends on ndc_pkg and ndc_divider.
module ndc_datapath #(
    parameter int unsigned WIDTH = ndc_pkg::DefWidth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ndc_pkg::t_cmd      i_cmd,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    input  logic [WIDTH-1:0]   i_c,
    output ndc_pkg::t_status   o_status,
    output logic               o_ok,
    output logic [WIDTH-1:0]   o_g
);
    import ndc_pkg::*;
    // coefficient magnitude stays below b, products below 2^(2W)
    localparam int unsigned SW = WIDTH + 2;
    localparam int unsigned PW = 2 * WIDTH;
    localparam int unsigned DW = 2 * WIDTH + 2;

    logic [WIDTH-1:0]     r_a, r_b, r_c, r_r0, r_r1, r_cg, r_bp, r_m;
    logic signed [SW-1:0] r_s0, r_s1;
    logic [PW-1:0]        r_prod;
    logic                 r_ok, r_neg;
    logic                 div_start, div_busy;
    logic [DW-1:0]        div_num, div_den, quo, rem;
    logic [WIDTH-1:0]     q_n, rem_n, xm_n, mul_x, mul_y;
    logic [PW-1:0]        prod_n;
    logic signed [SW-1:0] s_mag;

    assign q_n   = quo[WIDTH-1:0];
    assign rem_n = rem[WIDTH-1:0];
    assign s_mag = r_s0[SW-1] ? -r_s0 : r_s0;

    // x mod b' taken non-negative from the magnitude remainder
    assign xm_n  = (r_neg && rem_n != '0) ? r_bp - rem_n : rem_n;
    // one multiplier: (x mod b') * m, then a * x_min
    assign mul_x  = (i_cmd.op == t_OP_FINAL_MUL) ? r_a : xm_n;
    assign mul_y  = (i_cmd.op == t_OP_FINAL_MUL) ? rem_n : r_m;
    assign prod_n = PW'(mul_x) * PW'(mul_y);

    ndc_divider #(.W(DW)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_busy(div_busy), .o_quo(quo), .o_rem(rem)
    );

    always_comb begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (i_cmd.op)
            t_OP_DIV_START:  begin div_num = DW'(r_r0); div_den = DW'(r_r1); end
            t_OP_CG_START:   begin div_num = DW'(r_c); div_den = DW'(r_r0); end
            t_OP_BP_START:   begin div_num = DW'(r_b); div_den = DW'(r_r0); end
            t_OP_M_START:    begin div_num = DW'(r_cg); div_den = DW'(r_bp); end
            t_OP_XM_START:   begin div_num = DW'(s_mag); div_den = DW'(r_bp); end
            t_OP_XMIN_START: begin div_num = DW'(r_prod); div_den = DW'(r_bp); end
            default:         div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            t_OP_LOAD: begin
                r_a  <= i_a;
                r_b  <= i_b;
                r_c  <= i_c;
                // a zero weight a leaves b as the gcd
                r_r0 <= (i_a == '0) ? i_b : i_a;
                r_r1 <= i_b;
                r_s0 <= SW'(1);
                r_s1 <= '0;
            end
            t_OP_EUCLID_STEP: begin
                r_r0 <= r_r1;
                r_r1 <= rem_n;
                r_s0 <= r_s1;
                r_s1 <= r_s0 - SW'($signed({1'b0, q_n}) * r_s1);
            end
            t_OP_SAVE_CG: begin
                // with both weights zero the divider returns c as remainder
                r_cg <= q_n;
                r_ok <= (rem_n == '0);
            end
            t_OP_SAVE_BP:    r_bp   <= q_n;
            t_OP_SAVE_M:     r_m    <= rem_n;
            t_OP_XM_START:   r_neg  <= r_s0[SW-1];
            t_OP_MUL_START:  r_prod <= prod_n;
            t_OP_FINAL_MUL:  r_prod <= prod_n;
            default: ;
        endcase
    end

    assign o_status.div_busy = div_busy;
    assign o_status.r1_zero  = (r_r1 == '0);
    assign o_status.a_zero   = (r_a == '0);
    assign o_status.b_zero   = (r_b == '0);
    assign o_ok = (r_a == '0 || r_b == '0) ? r_ok : (r_ok && (r_prod <= PW'(r_c)));
    assign o_g  = r_r0;
endmodule

// ===== rtl/ndc_ctrl.sv =====
// Sequencer for the Euclid loop, scaling divisions and final check.
// Depends on ndc_pkg.
module ndc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ndc_pkg::t_status i_status,
    output ndc_pkg::t_cmd    o_cmd,
    output logic             o_take_result
);
    import ndc_pkg::*;
    typedef enum logic [3:0] {
        t_IDLE, t_CHK, t_EU_GO, t_EU_W, t_CG_W, t_BP_GO, t_BP_W, t_M_GO, t_M_W,
        t_XM_GO, t_XM_W, t_XMIN_GO, t_XMIN_W, t_DONE
    } t_state;
    t_state r_state;
    logic   r_out_valid;
    logic   degen;

    assign degen = i_status.a_zero || i_status.b_zero;

    // the divider raises busy at the start edge, so each wait state sees it at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                t_IDLE:    if (i_in_valid && !r_out_valid) r_state <= t_CHK;
                t_CHK:     r_state <= degen ? t_CG_W : t_EU_GO;
                t_EU_GO:   r_state <= i_status.r1_zero ? t_CG_W : t_EU_W;
                t_EU_W:    if (!i_status.div_busy) r_state <= t_EU_GO;
                t_CG_W:    if (!i_status.div_busy) r_state <= degen ? t_DONE : t_BP_GO;
                t_BP_GO:   r_state <= t_BP_W;
                t_BP_W:    if (!i_status.div_busy) r_state <= t_M_GO;
                t_M_GO:    r_state <= t_M_W;
                t_M_W:     if (!i_status.div_busy) r_state <= t_XM_GO;
                t_XM_GO:   r_state <= t_XM_W;
                t_XM_W:    if (!i_status.div_busy) r_state <= t_XMIN_GO;
                t_XMIN_GO: r_state <= t_XMIN_W;
                t_XMIN_W:  if (!i_status.div_busy) r_state <= t_DONE;
                t_DONE: begin
                    r_state     <= t_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: r_state <= t_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.op = t_OP_NONE;
        o_take_result = 1'b0;
        case (r_state)
            t_IDLE:    if (i_in_valid && !r_out_valid) o_cmd.op = t_OP_LOAD;
            t_CHK:     o_cmd.op = degen ? t_OP_CG_START : t_OP_NONE;
            t_EU_GO:   o_cmd.op = i_status.r1_zero ? t_OP_CG_START : t_OP_DIV_START;
            t_EU_W:    if (!i_status.div_busy) o_cmd.op = t_OP_EUCLID_STEP;
            t_CG_W:    if (!i_status.div_busy) o_cmd.op = t_OP_SAVE_CG;
            t_BP_GO:   o_cmd.op = t_OP_BP_START;
            t_BP_W:    if (!i_status.div_busy) o_cmd.op = t_OP_SAVE_BP;
            t_M_GO:    o_cmd.op = t_OP_M_START;
            t_M_W:     if (!i_status.div_busy) o_cmd.op = t_OP_SAVE_M;
            t_XM_GO:   o_cmd.op = t_OP_XM_START;
            t_XM_W:    if (!i_status.div_busy) o_cmd.op = t_OP_MUL_START;
            t_XMIN_GO: o_cmd.op = t_OP_XMIN_START;
            t_XMIN_W:  if (!i_status.div_busy) o_cmd.op = t_OP_FINAL_MUL;
            t_DONE:    o_take_result = 1'b1;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == t_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/nonneg_diophantine_check.sv =====
// Nonnegative linear Diophantine solution check: does a*x + b*y = c have x, y >= 0.
// Top level; depends on ndc_pkg, ndc_ctrl, ndc_datapath, ndc_divider and the defines header.
//
// Input channel: i_weight_a, i_weight_b, i_target with i_in_valid / o_in_ready.
// Output channel: o_solvable, o_common_divisor with o_out_valid / i_out_ready.
// One result per input; the inputs are captured at the accepting edge.
// All divisions share one restoring divider of 2*WIDTH+2 steps, each with
// a start and a save command from the sequencer.
// Work from the accepting edge to o_out_valid: with a zero weight one
// division; otherwise one division per Euclid iteration and five scaling
// divisions.
// One transaction is in flight at a time; the next is taken the cycle after
// the result has left the output register.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// pending result. A stalled receiver holds the result in the output register
// and the input side stays not ready until it is taken.
`include "nonneg_diophantine_check_defines.svh"
module nonneg_diophantine_check #(
    parameter int unsigned WIDTH = ndc_pkg::DefWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_weight_a,
    input  logic [WIDTH-1:0] i_weight_b,
    input  logic [WIDTH-1:0] i_target,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_solvable,
    output logic [WIDTH-1:0] o_common_divisor
);
    import ndc_pkg::*;
    t_cmd             cmd;
    t_status          status;
    logic             take, dp_ok;
    logic [WIDTH-1:0] dp_g;
    logic             r_solv;
    logic [WIDTH-1:0] r_g;
    logic             out_stall;
    logic [WIDTH:0]   out_word;

    ndc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd), .o_take_result(take)
    );

    ndc_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_a(i_weight_a), .i_b(i_weight_b),
        .i_c(i_target), .o_status(status), .o_ok(dp_ok), .o_g(dp_g)
    );

    // capture the result as the sequencer raises valid
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_g    <= dp_g;
            r_solv <= dp_ok;
        end
    end

    assign o_solvable       = r_solv;
    assign o_common_divisor = r_g;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_solvable, o_common_divisor};

    `NDC_ASSERT_IMPL(a_no_both, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "ready with result")
    `NDC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_stall, o_out_valid, "result dropped")
    `NDC_ASSERT_NEXT(a_data, i_clk, i_rst_n, out_stall, $stable(out_word), "result changed")
endmodule
